>>> sv/bsir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsir_pkg;

  // default store size
  localparam int DEF_CAPACITY = 16;

  // fixed field widths
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // request kinds
  localparam logic K_INSERT = 1'b0;
  localparam logic K_REMOVE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd4;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT
  } state_t;

endpackage

`default_nettype wire

>>> sv/bsir_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module bsir_mem import bsir_pkg::*; #(
  parameter int DEPTH = DEF_CAPACITY,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [IDX_W-1:0]   waddr,
  input  wire logic [VALUE_W-1:0] wdata,
  input  wire logic [IDX_W-1:0]   raddr,
  output logic      [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/bsir_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module bsir_seq import bsir_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  kind,
  input  wire logic [VALUE_W-1:0]    value,
  output logic                       done,
  output logic      [STATUS_W-1:0]   status,
  output logic      [COUNT_W-1:0]    count,
  // store port
  output logic                       we,
  output logic      [IDX_W-1:0]      waddr,
  output logic      [VALUE_W-1:0]    wdata,
  output logic      [IDX_W-1:0]      raddr,
  input  wire logic [VALUE_W-1:0]    rdata
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  state_t             state, state_next;
  logic               req_kind, req_kind_next;
  logic [VALUE_W-1:0] req_value, req_value_next;
  logic [CNT_W-1:0]   fill, fill_next;
  logic [CNT_W-1:0]   ptr, ptr_next;
  logic               pend, pend_next;
  logic [CNT_W-1:0]   pend_idx, pend_idx_next;
  logic               done_next;
  logic [STATUS_W-1:0] status_next;
  logic               more;
  logic               hit;

  // shared compare unit: stored word against the request value
  assign more = (ptr < fill);
  assign hit  = pend && (rdata == req_value);

  assign busy  = (state != S_IDLE);
  assign count = COUNT_W'(fill);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      pend  <= pend_next;
      done  <= done_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    req_kind  <= req_kind_next;
    req_value <= req_value_next;
    ptr       <= ptr_next;
    pend_idx  <= pend_idx_next;
    status    <= status_next;
  end

  // sequencer
  always_comb begin
    state_next     = state;
    req_kind_next  = req_kind;
    req_value_next = req_value;
    fill_next      = fill;
    ptr_next       = ptr;
    pend_next      = pend;
    pend_idx_next  = pend_idx;
    done_next      = 1'b0;
    status_next    = status;
    we             = 1'b0;
    waddr          = IDX_W'(fill);
    wdata          = req_value;
    raddr          = IDX_W'(ptr);

    unique case (state)
      S_IDLE: begin
        pend_next = 1'b0;
        ptr_next  = '0;
        if (start) begin
          req_kind_next  = kind;
          req_value_next = value;
          if (kind == K_INSERT && fill >= CAP) begin
            done_next   = 1'b1;
            status_next = ST_FULL;
          end else begin
            state_next = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        // issue the next read, compare the word read last cycle
        pend_next     = more;
        pend_idx_next = ptr;
        if (more) begin
          ptr_next = ptr + 1'b1;
        end
        if (hit) begin
          if (req_kind == K_INSERT) begin
            done_next   = 1'b1;
            status_next = ST_PRESENT;
            state_next  = S_IDLE;
          end else begin
            ptr_next   = pend_idx + 1'b1;
            pend_next  = 1'b0;
            state_next = S_SHIFT;
          end
        end else if (!pend && !more) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (req_kind == K_INSERT) begin
            we          = 1'b1;
            fill_next   = fill + 1'b1;
            status_next = ST_INSERTED;
          end else begin
            status_next = ST_MISSING;
          end
        end
      end

      S_SHIFT: begin
        // read entry i+1, write it back at i in the next cycle
        pend_next     = more;
        pend_idx_next = ptr;
        if (more) begin
          ptr_next = ptr + 1'b1;
        end
        if (pend) begin
          we    = 1'b1;
          waddr = IDX_W'(pend_idx - 1'b1);
          wdata = rdata;
        end else if (!more) begin
          fill_next   = fill - 1'b1;
          done_next   = 1'b1;
          status_next = ST_REMOVED;
          state_next  = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CAP)
    else $error("fill count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_INSERTED) |-> (fill == CNT_W'($past(fill) + 1'b1)))
    else $error("insert did not grow the count by one");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_REMOVED) |-> (fill == CNT_W'($past(fill) - 1'b1)))
    else $error("remove did not shrink the count by one");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (fill == CAP))
    else $error("full reported below capacity");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> (state != S_IDLE))
    else $error("store written while idle");

endmodule

`default_nettype wire

>>> sv/bounded_set_insert_remove.sv
// channel  | ports                    | handshake
// ---------+--------------------------+-------------------------------------
// request  | kind, value              | taken when start is high, busy low
// result   | status, count            | one cycle, marked by done
//
// One stored word is read and compared per cycle; done follows the last busy cycle.
// A full insert is answered without going busy; an insert of a new value or a miss scans every stored word.
// A remove searches up to the matching slot, then moves each later word down one slot to compact the set.
// Reset (rst, synchronous) empties the set; stored words need no clearing.
// The result is shown for one cycle and cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module bounded_set_insert_remove import bsir_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       kind,
  input  wire logic signed [VALUE_W-1:0]  value,
  output logic                            done,
  output logic             [STATUS_W-1:0] status,
  output logic             [COUNT_W-1:0]  count
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [VALUE_W-1:0] wdata;
  logic [IDX_W-1:0]   raddr;
  logic [VALUE_W-1:0] rdata;
  logic [VALUE_W-1:0] value_bits;

  assign value_bits = value;

  // search and compaction sequencer
  bsir_seq #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .kind   (kind),
    .value  (value_bits),
    .done   (done),
    .status (status),
    .count  (count),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr  (raddr),
    .rdata  (rdata)
  );

  // packed value store
  bsir_mem #(
    .DEPTH (CAPACITY),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bsir_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;

  // expected status and count of one result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic kind;
  logic signed [VALUE_W-1:0] value;
  logic done;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0] count;

  // mirror of the set contents
  logic signed [VALUE_W-1:0] held_words [DEF_CAPACITY];
  int held_fill;

  outcome_t expected_results[$];
  outcome_t head_result;
  logic signed [VALUE_W-1:0] value_pool [20];
  int sender_idle_pct;
  int error_count;
  int cycle_count;

  bounded_set_insert_remove uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .kind   (kind),
    .value  (value),
    .done   (done),
    .status (status),
    .count  (count)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bounded_set_insert_remove verification failed");
      $finish;
    end
  end

  // apply one request to the mirror and return what the block must report
  function automatic outcome_t apply_request(input logic k, input logic signed [VALUE_W-1:0] v);
    outcome_t res;
    int hit;
    hit = held_fill;
    for (int i = 0; i < held_fill; i++) begin
      if (hit == held_fill && held_words[i] == v) hit = i;
    end
    if (k == K_INSERT) begin
      // full check comes ahead of the search
      if (held_fill >= DEF_CAPACITY) begin
        res.status = ST_FULL;
      end else if (hit < held_fill) begin
        res.status = ST_PRESENT;
      end else begin
        held_words[held_fill] = v;
        held_fill++;
        res.status = ST_INSERTED;
      end
    end else begin
      if (hit < held_fill) begin
        // close the gap left by the removed word
        for (int i = hit; i + 1 < held_fill; i++) held_words[i] = held_words[i + 1];
        held_fill--;
        res.status = ST_REMOVED;
      end else begin
        res.status = ST_MISSING;
      end
    end
    res.count = held_fill[COUNT_W-1:0];
    return res;
  endfunction

  // present one request word, wait for it to be taken
  task automatic send_word(input logic k, input logic signed [VALUE_W-1:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind  <= k;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(apply_request(k, v));
  endtask

  // check each result word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: status %0d count %0d", status, count);
        error_count++;
      end else begin
        head_result = expected_results.pop_front();
        if (status !== head_result.status) begin
          $error("status: expected %0d, actual %0d", head_result.status, status);
          error_count++;
        end
        if (count !== head_result.count) begin
          $error("count: expected %0d, actual %0d", head_result.count, count);
          error_count++;
        end
      end
    end
  end

  // extremes, duplicates, compaction, empty and full store
  task automatic test_directed();
    logic signed [VALUE_W-1:0] last_word;
    sender_idle_pct = 0;
    send_word(K_REMOVE, 32'sd5);
    send_word(K_INSERT, 32'sh80000000);
    send_word(K_INSERT, 32'sh7fffffff);
    send_word(K_INSERT, 32'sd0);
    send_word(K_INSERT, -32'sd1);
    send_word(K_INSERT, 32'sh7fffffff);
    send_word(K_REMOVE, 32'sd0);
    send_word(K_REMOVE, 32'sd0);
    last_word = 0;
    for (int i = 0; i < 13; i++) begin
      last_word = 32'sh5a5a0000 + (i * 32'sh01010101);
      send_word(K_INSERT, last_word);
    end
    // full wins over already present
    send_word(K_INSERT, -32'sd1);
    send_word(K_INSERT, 32'sd12345);
    send_word(K_REMOVE, 32'sh80000000);
    send_word(K_REMOVE, last_word);
  endtask

  // pool of values so that hits and a full store come up often
  task automatic refill_pool();
    for (int i = 0; i < 20; i++) begin
      case ($urandom_range(3))
        0: value_pool[i] = $urandom;
        1: value_pool[i] = $signed($urandom_range(15)) - 8;
        2: value_pool[i] = 32'sh80000000 + $urandom_range(3);
        default: value_pool[i] = 32'sh7fffffff - $urandom_range(3);
      endcase
    end
  endtask

  // random mix of inserts and removes with drifting bias
  task automatic run_random_mix(input int n_words, input int idle_pct);
    int insert_pct;
    int r;
    logic k;
    logic signed [VALUE_W-1:0] v;
    sender_idle_pct = idle_pct;
    refill_pool();
    insert_pct = 50;
    for (int n = 0; n < n_words; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 20;
          1: insert_pct = 50;
          default: insert_pct = 80;
        endcase
      end
      k = ($urandom_range(99) < insert_pct) ? K_INSERT : K_REMOVE;
      r = $urandom_range(99);
      if (k == K_REMOVE) begin
        if (r < 65 && held_fill > 0) v = held_words[$urandom_range(held_fill - 1)];
        else if (r < 90) v = value_pool[$urandom_range(19)];
        else v = $urandom;
      end else begin
        if (r < 15 && held_fill > 0) v = held_words[$urandom_range(held_fill - 1)];
        else if (r < 80) v = value_pool[$urandom_range(19)];
        else v = $urandom;
      end
      send_word(k, v);
    end
  endtask

  task automatic test_back_to_back();
    run_random_mix(420, 0);
  endtask

  task automatic test_sparse_requests();
    run_random_mix(400, 88);
  endtask

  task automatic test_dense_again();
    run_random_mix(400, 0);
  endtask

  task automatic test_moderate_gaps();
    run_random_mix(400, 23);
  endtask

  initial begin
    rst   <= 1'b1;
    start <= 1'b0;
    kind  <= K_INSERT;
    value <= '0;
    held_fill = 0;
    error_count = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_back_to_back();
    test_sparse_requests();
    test_dense_again();
    test_moderate_gaps();

    // drain
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("bounded_set_insert_remove verification clean");
    end else begin
      $display("bounded_set_insert_remove verification failed");
    end
    $finish;
  end

endmodule
